/* src/pss_pkg.sv */
// Shared types and constants for the position speed smoother.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package pss_pkg;

   // field widths
   localparam int POS_W   = 11;
   localparam int CFG_W   = 16;
   localparam int CM_W    = 27;
   localparam int SQ_W    = 54;
   localparam int RAD_W   = 56;
   localparam int ROOT_W  = 28;
   localparam int REM_W   = 30;
   localparam int PROD_W  = 40;
   localparam int SPEED_W = 24;
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 27;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // divide by 1600: drop six bits, then divide by 25 as a multiply by
   // ceil(2^34 / 25) and a shift by 34; exact for every operand below 2^29,
   // which covers every product below the saturation limit
   localparam int DIV_LO    = 6;
   localparam int DIV_A_W   = 29;
   localparam int DIV_B_W   = 30;
   localparam int DIV_P_W   = DIV_A_W + DIV_B_W;
   localparam int DIV_SHIFT = 34;

   // iteration counts
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int CNT_W      = 5;

   // constants: 29.97 fps applied as *2997 / 1600
   localparam logic [11:0]          FPS_NUM   = 12'd2997;
   localparam logic [DIV_B_W-1:0]   DIV_RECIP = 30'd687194768;
   localparam logic [PROD_W-1:0]    SAT_LIMIT = 40'd26843545600;  // 1600 << 24
   localparam logic [SPEED_W-1:0]   SPEED_MAX = 24'hFF_FFFF;
   localparam logic [CFG_W-1:0]     CFG_RESET = 16'd4096;

   // datapath commands
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE  = 4'd0;
   localparam op_type OP_LOAD  = 4'd1;
   localparam op_type OP_MULX  = 4'd2;
   localparam op_type OP_MULY  = 4'd3;
   localparam op_type OP_DIFF  = 4'd4;
   localparam op_type OP_SQX   = 4'd5;
   localparam op_type OP_SQY   = 4'd6;
   localparam op_type OP_SUM   = 4'd7;
   localparam op_type OP_ROOT  = 4'd8;
   localparam op_type OP_SCALE = 4'd9;
   localparam op_type OP_DIV   = 4'd10;
   localparam op_type OP_AVG   = 4'd11;

   typedef struct packed {
      op_type op;
   } cmd_type;

endpackage

`default_nettype wire

/* src/pss_datapath.sv */
// Datapath of the position speed smoother: shared multiplier, bit-pair square
// root, reciprocal divide by 1600, averaging and the result register. Depends on pss_pkg.
`default_nettype none

module pss_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pss_pkg::cmd_type              cmd,
   input  wire logic [pss_pkg::POS_W-1:0]     pos_x,
   input  wire logic [pss_pkg::POS_W-1:0]     pos_y,
   input  wire logic                          csr_wen,
   input  wire logic [pss_pkg::CFG_W-1:0]     csr_wdata,
   output logic      [pss_pkg::SPEED_W-1:0]   speed
);

   localparam int REM_W_EXT = pss_pkg::REM_W + 2;

   // control-visible state
   logic [pss_pkg::CFG_W-1:0]   cfg_ff, cfg_in;
   logic [pss_pkg::CM_W-1:0]    prev_x_ff, prev_x_in;
   logic [pss_pkg::CM_W-1:0]    prev_y_ff, prev_y_in;
   logic [pss_pkg::SPEED_W-1:0] avg_ff, avg_in;

   // payload registers
   logic [pss_pkg::POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [pss_pkg::CM_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [pss_pkg::CM_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [pss_pkg::SQ_W-1:0]    sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [pss_pkg::RAD_W-1:0]   rad_ff, rad_in;
   logic [pss_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [pss_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [pss_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [pss_pkg::SPEED_W-1:0] quo_ff, quo_in, out_ff, out_in;
   logic                        sat_ff, sat_in;

   // shared multiplier
   logic [pss_pkg::MUL_A_W-1:0] mul_a;
   logic [pss_pkg::MUL_B_W-1:0] mul_b;
   logic [pss_pkg::MUL_P_W-1:0] mul_p;

   // reciprocal multiplier for the divide
   logic [pss_pkg::DIV_A_W-1:0] div_a;
   logic [pss_pkg::DIV_P_W-1:0] div_p;

   // helpers
   logic [REM_W_EXT-1:0]        r_sh, trial;
   logic [pss_pkg::SPEED_W:0]   avg_sum;
   logic [pss_pkg::SPEED_W-1:0] spd;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         pss_pkg::OP_MULX: begin
            mul_a = {{(pss_pkg::MUL_A_W-pss_pkg::POS_W){1'b0}}, px_ff};
            mul_b = {{(pss_pkg::MUL_B_W-pss_pkg::CFG_W){1'b0}}, cfg_ff};
         end
         pss_pkg::OP_MULY: begin
            mul_a = {{(pss_pkg::MUL_A_W-pss_pkg::POS_W){1'b0}}, py_ff};
            mul_b = {{(pss_pkg::MUL_B_W-pss_pkg::CFG_W){1'b0}}, cfg_ff};
         end
         pss_pkg::OP_SQX: begin
            mul_a = {1'b0, dx_ff};
            mul_b = dx_ff;
         end
         pss_pkg::OP_SQY: begin
            mul_a = {1'b0, dy_ff};
            mul_b = dy_ff;
         end
         pss_pkg::OP_SCALE: begin
            mul_a = root_ff;
            mul_b = {{(pss_pkg::MUL_B_W-12){1'b0}}, pss_pkg::FPS_NUM};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // divide by 1600: prod / 64, then times the reciprocal of 25
   assign div_a = prod_ff[pss_pkg::DIV_LO +: pss_pkg::DIV_A_W];
   assign div_p = pss_pkg::DIV_P_W'(div_a) * pss_pkg::DIV_P_W'(pss_pkg::DIV_RECIP);

   // square root trial: remainder gets the next bit pair, trial is 4*root + 1
   assign r_sh  = {rem_ff, rad_ff[pss_pkg::RAD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   // saturated instantaneous speed and running average
   assign spd     = sat_ff ? pss_pkg::SPEED_MAX : quo_ff;
   assign avg_sum = {1'b0, spd} + {1'b0, avg_ff};

   always_comb begin
      cfg_in    = csr_wen ? csr_wdata : cfg_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      avg_in    = avg_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sqa_in    = sqa_ff;
      sqb_in    = sqb_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      sat_in    = sat_ff;
      out_in    = out_ff;
      case (cmd.op)
         pss_pkg::OP_LOAD: begin
            px_in = pos_x;
            py_in = pos_y;
         end
         pss_pkg::OP_MULX: cx_in = mul_p[pss_pkg::CM_W-1:0];
         pss_pkg::OP_MULY: cy_in = mul_p[pss_pkg::CM_W-1:0];
         // absolute deltas; the new position becomes the stored one
         pss_pkg::OP_DIFF: begin
            dx_in     = (cx_ff >= prev_x_ff) ? cx_ff - prev_x_ff : prev_x_ff - cx_ff;
            dy_in     = (cy_ff >= prev_y_ff) ? cy_ff - prev_y_ff : prev_y_ff - cy_ff;
            prev_x_in = cx_ff;
            prev_y_in = cy_ff;
         end
         pss_pkg::OP_SQX: sqa_in = mul_p[pss_pkg::SQ_W-1:0];
         pss_pkg::OP_SQY: sqb_in = mul_p[pss_pkg::SQ_W-1:0];
         pss_pkg::OP_SUM: begin
            rad_in  = {1'b0, {1'b0, sqa_ff} + {1'b0, sqb_ff}};
            rem_in  = '0;
            root_in = '0;
         end
         // one root bit per cycle
         pss_pkg::OP_ROOT: begin
            rad_in = {rad_ff[pss_pkg::RAD_W-3:0], 2'b00};
            if (r_sh >= trial) begin
               rem_in  = pss_pkg::REM_W'(r_sh - trial);
               root_in = {root_ff[pss_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = r_sh[pss_pkg::REM_W-1:0];
               root_in = {root_ff[pss_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         pss_pkg::OP_SCALE: prod_in = mul_p[pss_pkg::PROD_W-1:0];
         // saturation check and quotient in one step
         pss_pkg::OP_DIV: begin
            sat_in = prod_ff >= pss_pkg::SAT_LIMIT;
            quo_in = div_p[pss_pkg::DIV_SHIFT +: pss_pkg::SPEED_W];
         end
         pss_pkg::OP_AVG: begin
            avg_in = avg_sum[pss_pkg::SPEED_W:1];
            out_in = avg_sum[pss_pkg::SPEED_W:1];
         end
         default: begin
            out_in = out_ff;
         end
      endcase
   end

   // registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= pss_pkg::CFG_RESET;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         avg_ff    <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         avg_ff    <= avg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqa_ff  <= sqa_in;
      sqb_ff  <= sqb_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
      out_ff  <= out_in;
   end

   assign speed = out_ff;

endmodule

`default_nettype wire

/* src/pss_ctrl.sv */
// Controller of the position speed smoother: sequences the datapath and owns
// the input ready and result valid. Depends on pss_pkg.
`default_nettype none

module pss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output pss_pkg::cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MULX  = 4'd1;
   localparam logic [3:0] ST_MULY  = 4'd2;
   localparam logic [3:0] ST_DIFF  = 4'd3;
   localparam logic [3:0] ST_SQX   = 4'd4;
   localparam logic [3:0] ST_SQY   = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_ROOT  = 4'd7;
   localparam logic [3:0] ST_SCALE = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_AVG   = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [pss_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      valid_ff, valid_in;
   logic                      out_free;

   // result register can take a new beat when empty or draining now
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = pss_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = pss_pkg::OP_LOAD;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.op   = pss_pkg::OP_MULX;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            cmd.op   = pss_pkg::OP_MULY;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = pss_pkg::OP_DIFF;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.op   = pss_pkg::OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = pss_pkg::OP_SQY;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = pss_pkg::OP_SUM;
            cnt_in   = pss_pkg::CNT_W'(pss_pkg::ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = pss_pkg::OP_ROOT;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.op   = pss_pkg::OP_SCALE;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = pss_pkg::OP_DIV;
            state_in = ST_AVG;
         end
         // hold here until the result register frees up
         ST_AVG: begin
            if (out_free) begin
               cmd.op   = pss_pkg::OP_AVG;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set when a result is loaded, cleared when the beat is taken
   always_comb begin
      if (cmd.op == pss_pkg::OP_AVG) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

/* src/position_speed_smoother.sv */
// Top level of the position speed smoother: controller plus datapath.
// Depends on pss_pkg, pss_ctrl and pss_datapath.
//
// One beat in per video frame (pixel x, y), one smoothed speed beat out per
// beat in. Each position is scaled by cm_per_pixel (Q4.12), the distance to the
// previous position is taken with an exact floor square root, scaled by 29.97
// fps and averaged with the previous smoothed speed; output is Q16.8 cm/s,
// saturating. The stored position and average reset to zero, so the first beat
// measures from the origin. An item is worked in order: the accepting cycle, the
// scale, difference, square and sum steps, the one-bit-per-cycle square root,
// the 29.97 fps scale and the reciprocal divide by 1600, and the load of the
// result; no new beat is taken until the result is loaded. The result sits in
// an output register, so the block goes back to accepting while it waits; if
// the previous result is still unread when a new one is done, the block holds
// until it is taken. cm_per_pixel is written via csr_wen/csr_wdata and should
// only change while the block is idle.
`default_nettype none

module position_speed_smoother (
   input  wire logic        clock,
   input  wire logic        reset,
   // input beats: [10:0] pos_x, [21:11] pos_y, [23:22] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // result beats: [23:0] smoothed_speed
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,
   // configuration: cm_per_pixel
   input  wire logic        csr_wen,
   input  wire logic [15:0] csr_wdata
);

   pss_pkg::cmd_type cmd;

   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pos_x     (req_tdata[10:0]),
      .pos_y     (req_tdata[21:11]),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .speed     (rsp_tdata)
   );

   // block goes busy right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still ready after accepting a beat");

   // a new result only comes out of a busy block
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without an item in work");

   // loading a result returns the controller to idle
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("controller not idle after loading a result");

endmodule

`default_nettype wire
